>>> hw/rtl/ofp_pkg.sv
// Shared types, constants and the packet length table of the oximeter frame parser.
`timescale 1ns / 1ps
`default_nettype none
package ofp_pkg;

	// Packet geometry
	localparam int STORE_DEPTH = 9;               // header, high-bit byte, seven data bytes
	localparam int DATA_BYTES  = STORE_DEPTH - 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// Header bytes of the record packets
	localparam logic [7:0] HDR_SPOT   = 8'h09;
	localparam logic [7:0] HDR_TRIPLE = 8'h0f;
	localparam logic [7:0] PULSE_NONE = 8'hff;

	// Result kinds as seen on the kind port
	localparam logic [1:0] KIND_RECORD = 2'd0;
	localparam logic [1:0] KIND_PAD    = 2'd1;
	localparam logic [1:0] KIND_RESP   = 2'd2;

	// Work handed from the framer to the result builder
	typedef enum logic [1:0] {
		JOB_PAD,
		JOB_RESP,
		JOB_SPOT,
		JOB_TRIPLE
	} job_kind_t;

	typedef struct packed {
		job_kind_t                     kind;
		logic [7:0]                    hdr;     // header, or offending byte for padding
		logic [7:0]                    msb;     // high-bit byte (packet byte 1)
		logic [DATA_BYTES-1:0][7:0]    data;    // raw bytes 2..8, byte 2 lowest
		logic [3:0]                    len;
		logic                          started;
	} job_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  pulse;
		logic [7:0]  spo2;
		logic [15:0] perfusion;
		logic [7:0]  code;
		logic [55:0] payload;
		logic [2:0]  count;
		logic        started;
		logic        last;
	} res_t;

	// Packet length from the low five bits of the header; zero = unknown header
	function automatic logic [3:0] pkt_len(input logic [4:0] code);
		logic [3:0] len;
		case (code)
			5'd2, 5'd3, 5'd4, 5'd5, 5'd17, 5'd19, 5'd20: len = 4'd9;
			5'd6, 5'd10, 5'd11:                          len = 4'd4;
			5'd7, 5'd8, 5'd15, 5'd18:                    len = 4'd8;
			5'd9:                                        len = 4'd6;
			5'd12:                                       len = 4'd2;
			5'd14, 5'd16:                                len = 4'd3;
			default:                                     len = 4'd0;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ofp_front.sv
// Framer: takes bytes, tracks import and hunt state, hands finished packets on as jobs.
`timescale 1ns / 1ps
`default_nettype none
module ofp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic          cmd,
	input  wire logic [7:0]    rx_byte,
	output ofp_pkg::job_t      job,
	output logic               job_push
);
	import ofp_pkg::*;

	logic [7:0] hdr_q;
	logic [7:0] st_q [STORE_DEPTH-1];   // packet bytes 1..8
	logic [3:0] idx_q;
	logic [3:0] len_q;
	logic       reading_q;
	logic [7:0] imp_hdr_q;
	logic       hunting_q;

	logic [3:0] idx_nxt;
	logic [2:0] slot;
	logic       finish;
	logic       begin_frm;
	logic       pad;
	logic [3:0] b_len;
	logic [7:0] merged [STORE_DEPTH-1];

	assign b_len   = pkt_len(rx_byte[4:0]);
	assign idx_nxt = idx_q + 4'd1;
	assign slot    = 3'(idx_q - 4'd1);

	always_comb begin
		for (int k = 0; k < STORE_DEPTH - 1; k++) begin
			merged[k] = (slot == 3'(k)) ? rx_byte : st_q[k];
		end
	end

	// Decode of one request
	always_comb begin
		finish    = 1'b0;
		begin_frm = 1'b0;
		pad       = 1'b0;
		if (!cmd) begin
			if (hunting_q) begin
				begin_frm = (rx_byte == imp_hdr_q);
			end else if (idx_q == 4'd0) begin
				if (reading_q && rx_byte != imp_hdr_q) begin
					pad = 1'b1;
				end else begin
					begin_frm = (b_len != 4'd0);
				end
			end else begin
				finish = (idx_nxt >= len_q) || (idx_nxt >= 4'(STORE_DEPTH));
			end
		end
	end

	// Job contents
	always_comb begin
		job.hdr     = pad ? rx_byte : hdr_q;
		job.msb     = merged[0];
		for (int j = 0; j < DATA_BYTES; j++) begin
			job.data[j] = merged[j+1];
		end
		job.len     = len_q;
		job.started = 1'b0;
		job.kind    = JOB_PAD;
		job_push    = 1'b0;
		if (accept && pad) begin
			job_push = 1'b1;
		end else if (accept && finish) begin
			if (!reading_q) begin
				if (hdr_q inside {HDR_SPOT, HDR_TRIPLE}) begin
					job.started = 1'b1;
					job.kind    = (hdr_q == HDR_SPOT) ? JOB_SPOT : JOB_TRIPLE;
					job_push    = 1'b1;
				end else begin
					job.kind = JOB_RESP;
					job_push = 1'b1;
				end
			end else if (hdr_q == HDR_SPOT) begin
				job.kind = JOB_SPOT;
				job_push = 1'b1;
			end else if (hdr_q == HDR_TRIPLE) begin
				job.kind = JOB_TRIPLE;
				job_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			len_q     <= '0;
			reading_q <= 1'b0;
			imp_hdr_q <= '0;
			hunting_q <= 1'b0;
		end else if (accept) begin
			if (cmd) begin
				reading_q <= 1'b0;
				hunting_q <= 1'b0;
				imp_hdr_q <= '0;
				idx_q     <= '0;
			end else if (begin_frm) begin
				hunting_q <= 1'b0;
				len_q     <= b_len;
				idx_q     <= 4'd1;
			end else if (pad) begin
				hunting_q <= 1'b1;
			end else if (finish) begin
				idx_q <= '0;
				if (!reading_q && (hdr_q inside {HDR_SPOT, HDR_TRIPLE})) begin
					reading_q <= 1'b1;
					imp_hdr_q <= hdr_q;
				end
			end else if (idx_q != 4'd0) begin
				idx_q <= idx_nxt;
			end
		end
	end

	// Packet store, no reset
	always_ff @(posedge clk) begin
		if (accept && !cmd && begin_frm) begin
			hdr_q <= rx_byte;
		end
		if (accept && !cmd && !hunting_q && idx_q != 4'd0) begin
			st_q[slot] <= rx_byte;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/ofp_job_queue.sv
// Short job queue between the framer and the result builder.
`timescale 1ns / 1ps
`default_nettype none
module ofp_job_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ofp_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output ofp_pkg::job_t      head_job
);
	import ofp_pkg::*;

	job_t               mem [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/ofp_back.sv
// Result builder: restores high bits and expands a job into one or three results.
`timescale 1ns / 1ps
`default_nettype none
module ofp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire ofp_pkg::job_t job,
	output logic               job_pop,
	output logic               empty,
	input  wire logic          pop,
	output ofp_pkg::res_t      res
);
	import ofp_pkg::*;

	res_t                       res_q;
	logic                       out_valid_q;
	logic [1:0]                 sub_q;
	logic [DATA_BYTES-1:0][7:0] rst;
	logic                       can_load;
	res_t                       nres;
	logic [2:0]                 cnt;
	logic [7:0]                 sp;
	logic [7:0]                 pu;

	assign empty    = !out_valid_q;
	assign res      = res_q;
	assign can_load = !out_valid_q || pop;
	assign job_pop  = job_valid && can_load && nres.last;

	// Put the high bits back
	always_comb begin
		for (int j = 0; j < DATA_BYTES; j++) begin
			rst[j] = {job.msb[j], job.data[j][6:0]};
		end
	end

	assign cnt = 3'(job.len - 4'd2);

	always_comb begin
		sp = rst[0];
		pu = rst[1];
		case (sub_q)
			2'd1:    begin sp = rst[2]; pu = rst[3]; end
			2'd2:    begin sp = rst[4]; pu = rst[5]; end
			default: begin sp = rst[0]; pu = rst[1]; end
		endcase
	end

	always_comb begin
		nres         = '0;
		nres.code    = job.hdr;
		nres.started = job.started;
		nres.last    = 1'b1;
		case (job.kind)
			JOB_PAD: begin
				nres.kind    = KIND_PAD;
				nres.started = 1'b0;
			end
			JOB_RESP: begin
				nres.kind    = KIND_RESP;
				nres.count   = cnt;
				nres.started = 1'b0;
				for (int j = 0; j < DATA_BYTES; j++) begin
					nres.payload[8*j +: 8] = (3'(j) < cnt) ? rst[j] : 8'd0;
				end
			end
			JOB_SPOT: begin
				nres.kind = KIND_RECORD;
				if (rst[0] != 8'd0 && rst[1] != 8'd0) begin
					nres.spo2      = rst[0];
					nres.pulse     = rst[1];
					nres.perfusion = {rst[3], rst[2]};
				end
			end
			JOB_TRIPLE: begin
				nres.kind = KIND_RECORD;
				nres.last = (sub_q == 2'd2);
				if (pu != PULSE_NONE) begin
					nres.spo2  = sp;
					nres.pulse = pu;
				end
			end
			default: begin
				nres.kind = KIND_PAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= '0;
		end else if (job_valid && can_load) begin
			out_valid_q <= 1'b1;
			sub_q       <= nres.last ? 2'd0 : sub_q + 2'd1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && can_load) begin
			res_q <= nres;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/oximeter_frame_parser.sv
// Top level of the oximeter frame parser: framer, job queue and result builder.
`timescale 1ns / 1ps
`default_nettype none
// Parses the byte stream of a pulse oximeter link. Each request carries either a
// received byte (cmd low) or an end-import command (cmd high). Packet length comes
// from the low five bits of the header; byte 1 holds the high bits of bytes 2 and up,
// which are restored. Header 0x09 gives one measurement record, 0x0f three; the first
// such packet switches the block into import mode and its records carry
// import_started. Other packets outside an import give one response result with the
// restored payload. In import mode a wrong header gives one padding record, after
// which bytes are dropped until the import header shows up again. Unknown headers
// outside an import are dropped. Rate: one byte per clock while full is low; the
// framer takes a byte every cycle that a request is accepted, and the result builder
// issues one result per cycle while its output register is empty or popped, so a 0x0f
// packet occupies it for three results. A two-entry job queue and a one-entry output
// register absorb that. With pop held high, full rises only when a wrong header comes
// straight after the last byte of a 0x0f packet in an import; otherwise it rises only
// when the consumer holds off pop. Jobs pass the queue, then the output register.
module oximeter_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        cmd,
	input  wire logic [7:0]  rx_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [7:0]       pulse,
	output logic [7:0]       spo2,
	output logic [15:0]      perfusion,
	output logic [7:0]       response_code,
	output logic [55:0]      payload,
	output logic [2:0]       payload_count,
	output logic             import_started,
	output logic             last
);
	import ofp_pkg::*;

	logic  accept;
	job_t  fr_job;
	logic  fr_push;
	logic  q_pop;
	logic  q_valid;
	job_t  q_job;
	res_t  res;

	// A request is taken whenever the queue has room, whether or not it ends a packet
	assign accept = push && !full;

	ofp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.rx_byte  (rx_byte),
		.job      (fr_job),
		.job_push (fr_push)
	);

	ofp_job_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fr_push),
		.push_job   (fr_job),
		.full       (full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (q_job)
	);

	ofp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_job),
		.job_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign kind           = res.kind;
	assign pulse          = res.pulse;
	assign spo2           = res.spo2;
	assign perfusion      = res.perfusion;
	assign response_code  = res.code;
	assign payload        = res.payload;
	assign payload_count  = res.count;
	assign import_started = res.started;
	assign last           = res.last;

endmodule
`default_nettype wire
